// ===== hdl/rhr_pkg.sv =====
// Shared types, constants and the divider step for the hue rotation pipeline.
`default_nettype none
package rhr_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_SEC       = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;
    localparam int HUE_THIRD     = HUE_FULL / 3;
    localparam int QUO_BITS      = 17;
    localparam int REM_BITS      = 25;
    localparam int DVS_BITS      = 9;
    localparam int DIV_STAGES    = QUO_BITS;
    // floor(2^20 / 15), reciprocal for the divide by 15
    localparam logic [16:0] RECIP15 = 17'd69905;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } hue_sec_t;

    typedef enum logic [1:0] {
        MODE_UP   = 2'd0,
        MODE_TOP  = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_LOW  = 2'd3
    } ch_mode_t;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [DVS_BITS-1:0] dvs;
        logic [QUO_BITS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [31:0] color;
        logic [14:0] step;
        logic        bypass;
        logic        grey;
        hue_sec_t    sec;
        logic        neg;
    } side_t;

    // one restoring divide step: quotient bit sh
    function automatic div_lane_t div_step(input div_lane_t x, input logic [4:0] sh);
        logic [REM_BITS:0] trial;
        div_lane_t         y;
        trial = {{(REM_BITS+1-DVS_BITS){1'b0}}, x.dvs} << sh;
        y = x;
        if ({1'b0, x.rem} >= trial) begin
            y.rem     = x.rem - trial[REM_BITS-1:0];
            y.quo[sh] = 1'b1;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rgb_hue_rotate.sv =====
// Top level: pipelined RGB hue rotation through HSL space.
`default_nettype none
// Rotates the hue of one ARGB pixel per request by s_tdata hue_step (1/64 degree
// units, taken modulo 360 degrees); alpha passes through and a zero step returns
// the pixel as it came. Fully pipelined: one pixel per clock when not stalled.
// The saturation and hue divisions run side by side in a 17-stage restoring
// divider, one quotient bit per stage; lightness (a divide by 510) is formed by
// shift-add in the front end and rides along with the divider. The remaining
// stages do the hue wrap, the lightness/saturation multiply and the per-channel
// ramps. A stall on m_tready holds the whole pipeline.
module rgb_hue_rotate (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // color_in[31:0], hue_step[46:32], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // color_out[31:0]
);
    import rhr_pkg::*;

    typedef struct packed {
        side_t       sd;
        logic [15:0] l;
        logic [15:0] s;
        logic [14:0] h0;
    } sta_t;

    typedef struct packed {
        side_t       sd;
        logic [15:0] l;
        logic [15:0] s;
        logic [14:0] hs;
        logic [16:0] ph;
    } stb_t;

    typedef struct packed {
        side_t            sd;
        logic [15:0]      l;
        logic [16:0]      v2;
        logic [7:0]       gch;
        logic [2:0][15:0] t;
    } stc_t;

    typedef struct packed {
        side_t            sd;
        logic [7:0]       gch;
        logic [16:0]      v1;
        logic [16:0]      v2;
        logic [16:0]      span;
        logic [2:0][11:0] tt;
        logic [5:0]       mode;
    } std_t;

    typedef struct packed {
        side_t            sd;
        logic [7:0]       gch;
        logic [16:0]      v1;
        logic [16:0]      v2;
        logic [2:0][19:0] y;
        logic [5:0]       mode;
    } ste_t;

    typedef struct packed {
        side_t            sd;
        logic [7:0]       gch;
        logic [16:0]      v1;
        logic [16:0]      v2;
        logic [2:0][19:0] y;
        logic [2:0][16:0] q0;
        logic [5:0]       mode;
    } stf_t;

    typedef struct packed {
        side_t            sd;
        logic [7:0]       gch;
        logic [2:0][17:0] v;
    } stg_t;

    logic en;

    side_t       in_reg;
    logic        in_vld_reg;

    logic [16:0] dl_reg [0:DIV_STAGES];
    div_lane_t   ds_reg [0:DIV_STAGES];
    div_lane_t   dh_reg [0:DIV_STAGES];
    side_t       dsd_reg [0:DIV_STAGES];
    logic        dv_reg [0:DIV_STAGES];

    sta_t a_reg, a_next;
    stb_t b_reg, b_next;
    stc_t c_reg, c_next;
    std_t d_reg, d_next;
    ste_t e_reg, e_next;
    stf_t f_reg, f_next;
    stg_t g_reg, g_next;
    logic [31:0] out_reg, out_next;
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg;
    logic out_vld_reg;

    assign en       = ~out_vld_reg | m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // input register
    side_t in_next;
    always_comb begin
        in_next        = '0;
        in_next.color  = s_tdata[31:0];
        in_next.step   = s_tdata[46:32];
        in_next.bypass = (s_tdata[46:32] == 15'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
        if (en) begin
            in_reg <= in_next;
        end
    end

    // forward conversion front end: extremes, difference, divider operands
    logic [7:0]  r, g, b, mx, mn, d, anum;
    logic [8:0]  sum, den;
    logic signed [8:0] num;
    logic [19:0] hdiv;
    logic [16:0] lsc, lval;
    side_t       sd0;
    always_comb begin
        r    = in_reg.color[23:16];
        g    = in_reg.color[15:8];
        b    = in_reg.color[7:0];
        mx   = (r > g) ? r : g;
        mx   = (mx > b) ? mx : b;
        mn   = (r < g) ? r : g;
        mn   = (mn < b) ? mn : b;
        d    = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        den  = (sum < 9'd255) ? sum : 9'd510 - sum;
        // L = 128*sum + (128*sum)/255, the /255 done as (y + (y >> 8) + 1) >> 8
        lsc  = {1'b0, sum, 7'd0} + {9'd0, sum[8:1]} + 17'd1;
        lval = {1'b0, sum, 7'd0} + {8'd0, lsc[16:8]};
        sd0  = in_reg;
        sd0.grey = (d == 8'd0);
        if (mx == r) begin
            sd0.sec = SEC_RED;
            num     = $signed({1'b0, g}) - $signed({1'b0, b});
        end else if (mx == g) begin
            sd0.sec = SEC_GREEN;
            num     = $signed({1'b0, b}) - $signed({1'b0, r});
        end else begin
            sd0.sec = SEC_BLUE;
            num     = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        sd0.neg = num[8];
        anum    = num[8] ? 8'(-num) : num[7:0];
        hdiv    = {anum, 12'd0} - {4'd0, anum, 8'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= in_vld_reg;
        end
        if (en) begin
            dsd_reg[0] <= sd0;
            dl_reg[0]  <= lval;
            ds_reg[0]  <= '{rem: {1'b0, d, 16'd0}, dvs: sd0.grey ? 9'd1 : den, quo: '0};
            dh_reg[0]  <= '{rem: {5'd0, hdiv}, dvs: sd0.grey ? 9'd1 : {1'b0, d}, quo: '0};
        end
    end

    // divider pipeline, one quotient bit per stage, msb first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
            if (en) begin
                dsd_reg[j+1] <= dsd_reg[j];
                dl_reg[j+1]  <= dl_reg[j];
                ds_reg[j+1]  <= div_step(ds_reg[j], 5'(DIV_STAGES - 1 - j));
                dh_reg[j+1]  <= div_step(dh_reg[j], 5'(DIV_STAGES - 1 - j));
            end
        end
    end

    // stage A: saturate L and S, signed hue
    logic signed [17:0] base, hv;
    always_comb begin
        a_next.sd = dsd_reg[DIV_STAGES];
        a_next.l  = dl_reg[DIV_STAGES][16] ? 16'hffff : dl_reg[DIV_STAGES][15:0];
        if (dsd_reg[DIV_STAGES].grey) begin
            a_next.s = 16'd0;
        end else begin
            a_next.s = ds_reg[DIV_STAGES].quo[16] ? 16'hffff : ds_reg[DIV_STAGES].quo[15:0];
        end
        case (dsd_reg[DIV_STAGES].sec)
            SEC_RED:   base = 18'sd0;
            SEC_GREEN: base = 18'(2 * HUE_SEC);
            SEC_BLUE:  base = 18'(4 * HUE_SEC);
            default:   base = 18'sd0;
        endcase
        if (dsd_reg[DIV_STAGES].neg) begin
            hv = base - $signed({1'b0, dh_reg[DIV_STAGES].quo});
        end else begin
            hv = base + $signed({1'b0, dh_reg[DIV_STAGES].quo});
        end
        if (dsd_reg[DIV_STAGES].grey) begin
            hv = 18'sd0;
        end
        a_next.h0 = hv[17] ? 15'(hv + 18'(HUE_FULL)) : hv[14:0];
    end

    // stage B: rotate hue, L*S product
    logic [15:0] hsum;
    logic [16:0] mlt;
    logic [32:0] prod;
    always_comb begin
        b_next.sd = a_reg.sd;
        b_next.l  = a_reg.l;
        b_next.s  = a_reg.s;
        hsum = {1'b0, a_reg.h0} + {1'b0, a_reg.sd.step};
        if (hsum >= 16'(2 * HUE_FULL)) begin
            b_next.hs = 15'(hsum - 16'(2 * HUE_FULL));
        end else if (hsum >= 16'(HUE_FULL)) begin
            b_next.hs = 15'(hsum - 16'(HUE_FULL));
        end else begin
            b_next.hs = hsum[14:0];
        end
        mlt  = {~a_reg.l[15], a_reg.s};
        prod = {17'd0, a_reg.l} * {16'd0, mlt};
        b_next.ph = prod[32:16];
    end

    // stage C: v2, grey level, channel angles
    logic [23:0] gw;
    logic [15:0] tr, tb;
    always_comb begin
        c_next.sd = b_reg.sd;
        c_next.l  = b_reg.l;
        if (!b_reg.l[15]) begin
            c_next.v2 = b_reg.ph;
        end else begin
            c_next.v2 = ({1'b0, b_reg.l} + {1'b0, b_reg.s}) - b_reg.ph;
        end
        gw = {b_reg.l, 8'd0} - {8'd0, b_reg.l};
        c_next.gch = gw[23:16];
        tr = {1'b0, b_reg.hs} + 16'(HUE_THIRD);
        tb = {1'b0, b_reg.hs} + 16'(2 * HUE_THIRD);
        c_next.t[0] = (tr >= 16'(HUE_FULL)) ? tr - 16'(HUE_FULL) : tr;   // red
        c_next.t[1] = {1'b0, b_reg.hs};                                  // green
        c_next.t[2] = (tb >= 16'(HUE_FULL)) ? tb - 16'(HUE_FULL) : tb;   // blue
    end

    // stage D: v1, span, per-channel ramp select
    logic [16:0] l2, v1, v2m;
    always_comb begin
        d_next.sd  = c_reg.sd;
        d_next.gch = c_reg.gch;
        l2  = {c_reg.l, 1'b0};
        v1  = (l2 >= c_reg.v2) ? l2 - c_reg.v2 : 17'd0;
        v2m = (c_reg.v2 < v1) ? v1 : c_reg.v2;
        d_next.v1   = v1;
        d_next.v2   = v2m;
        d_next.span = v2m - v1;
        for (int i = 0; i < 3; i++) begin
            if (c_reg.t[i] < 16'(HUE_SEC)) begin
                d_next.mode[2*i +: 2] = MODE_UP;
                d_next.tt[i]          = c_reg.t[i][11:0];
            end else if (c_reg.t[i] < 16'(3 * HUE_SEC)) begin
                d_next.mode[2*i +: 2] = MODE_TOP;
                d_next.tt[i]          = 12'd0;
            end else if (c_reg.t[i] < 16'(4 * HUE_SEC)) begin
                d_next.mode[2*i +: 2] = MODE_DOWN;
                d_next.tt[i]          = 12'(16'(4 * HUE_SEC) - c_reg.t[i]);
            end else begin
                d_next.mode[2*i +: 2] = MODE_LOW;
                d_next.tt[i]          = 12'd0;
            end
        end
    end

    // stage E: span * angle, then /256 as first part of /3840
    logic [2:0][28:0] sp;
    always_comb begin
        e_next.sd   = d_reg.sd;
        e_next.gch  = d_reg.gch;
        e_next.v1   = d_reg.v1;
        e_next.v2   = d_reg.v2;
        e_next.mode = d_reg.mode;
        for (int i = 0; i < 3; i++) begin
            sp[i]       = {12'd0, d_reg.span} * {17'd0, d_reg.tt[i]};
            e_next.y[i] = sp[i][27:8];
        end
    end

    // stage F: estimate y / 15 by reciprocal
    logic [2:0][36:0] rp;
    always_comb begin
        f_next.sd   = e_reg.sd;
        f_next.gch  = e_reg.gch;
        f_next.v1   = e_reg.v1;
        f_next.v2   = e_reg.v2;
        f_next.mode = e_reg.mode;
        f_next.y    = e_reg.y;
        for (int i = 0; i < 3; i++) begin
            rp[i]        = {17'd0, e_reg.y[i]} * {20'd0, RECIP15};
            f_next.q0[i] = rp[i][36:20];
        end
    end

    // stage G: correct the estimate by one, pick channel level
    logic [2:0][20:0] rm;
    logic [2:0][16:0] qc;
    always_comb begin
        g_next.sd  = f_reg.sd;
        g_next.gch = f_reg.gch;
        for (int i = 0; i < 3; i++) begin
            rm[i] = {1'b0, f_reg.y[i]} - ({f_reg.q0[i], 4'd0} - {4'd0, f_reg.q0[i]});
            qc[i] = (rm[i] >= 21'd15) ? f_reg.q0[i] + 17'd1 : f_reg.q0[i];
            case (ch_mode_t'(f_reg.mode[2*i +: 2]))
                MODE_UP, MODE_DOWN: g_next.v[i] = {1'b0, f_reg.v1} + {1'b0, qc[i]};
                MODE_TOP:           g_next.v[i] = {1'b0, f_reg.v2};
                MODE_LOW:           g_next.v[i] = {1'b0, f_reg.v1};
                default:            g_next.v[i] = {1'b0, f_reg.v1};
            endcase
        end
    end

    // output stage: scale to 8 bits and pack
    logic [2:0][25:0] cw;
    logic [2:0][7:0]  ch;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cw[i] = {g_reg.v[i], 8'd0} - {8'd0, g_reg.v[i]};
            ch[i] = (cw[i][25:16] > 10'd255) ? 8'hff : cw[i][23:16];
        end
        if (g_reg.sd.bypass) begin
            out_next = g_reg.sd.color;
        end else if (g_reg.sd.grey) begin
            out_next = {g_reg.sd.color[31:24], g_reg.gch, g_reg.gch, g_reg.gch};
        end else begin
            out_next = {g_reg.sd.color[31:24], ch[0], ch[1], ch[2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg   <= dv_reg[DIV_STAGES];
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            out_vld_reg <= g_vld_reg;
        end
        if (en) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            d_reg   <= d_next;
            e_reg   <= e_next;
            f_reg   <= f_next;
            g_reg   <= g_next;
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire
